// ===== rtl/slot_pool_bag_unit_assert.svh =====
// Assertion macros for the slot pool bag unit.
// Depends on nothing; included by slot_pool_bag_unit only.
`ifndef SLOT_POOL_BAG_UNIT_ASSERT_SVH
`define SLOT_POOL_BAG_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SPB_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("slot pool bag: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define SPB_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("slot pool bag: next-cycle check failed");
`else
`define SPB_ASSERT_IMPLY(label, clk, rst, pre, post)
`define SPB_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== rtl/spb_pkg.sv =====
// Types and constants of the slot pool bag unit.
// Depends on nothing; used by slot_pool_bag_unit.
package spb_pkg;

   localparam int SLOTS       = 64;
   localparam int HANDLE_BITS = 32;
   localparam int IDX_W       = $clog2(SLOTS);
   localparam int CNT_W       = $clog2(SLOTS + 1);

   // Operation codes carried in the request word.
   localparam logic [2:0] OP_INSERT       = 3'd0;
   localparam logic [2:0] OP_INSERT_AT    = 3'd1;
   localparam logic [2:0] OP_REMOVE_FIRST = 3'd2;
   localparam logic [2:0] OP_REMOVE_AT    = 3'd3;
   localparam logic [2:0] OP_REMOVE_ALL   = 3'd4;

   typedef enum logic [2:0] {
      STS_DONE    = 3'd0,
      STS_MISS    = 3'd1,
      STS_FULL    = 3'd2,
      STS_UNALLOC = 3'd3,
      STS_ZERO    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_FIND,
      FSM_FETCH,
      FSM_SWEEP
   } fsm_type;

   typedef struct packed {
      logic [2:0]             opcode;
      logic [IDX_W-1:0]       slot_index;
      logic [HANDLE_BITS-1:0] handle;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [IDX_W-1:0]       result_slot;
      logic [HANDLE_BITS-1:0] removed_handle;
      logic [CNT_W-1:0]       removed_count;
      logic [CNT_W-1:0]       held_count;
      logic [CNT_W-1:0]       allocated_count;
   } rsp_type;

endpackage

// ===== rtl/slot_pool_bag_unit.sv =====
// Slot pool bag unit: a bag of data handles kept in ordered slots.
// A request word is taken at a rising edge where start is high and busy is
// low. Exactly one response word follows on rsp_data, marked by rsp_strobe
// for a single cycle; the receiver always takes it and cannot stall.
// Handles live in a 64-entry memory with a registered read; the
// occupancy bits, the held count and the allocated count are flip-flops.
// Steps from acceptance to strobe:
//   insert at slot, unused codes, rejections other than full: answered from idle
//   remove at slot: the memory read, then the response
//   insert: one occupancy bit checked per cycle
//   remove first: scan, then the memory read
//   remove all: one memory read per slot, then compare
// The longest case is set by the per-slot sweep over the
// handle memory's single read port. busy drops in the cycle the strobe is
// high, so the next request may be taken then.
// Reset clears the occupancy bits, sets the held count to zero and the
// allocated count to one; handle memory contents stay undefined and are
// only used where the occupancy bit is set.
module slot_pool_bag_unit (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  spb_pkg::req_type req_data,
   output logic            rsp_strobe,
   output spb_pkg::rsp_type rsp_data
);
   import spb_pkg::*;

   `include "slot_pool_bag_unit_assert.svh"

   fsm_type                state_ff, state_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [IDX_W-1:0]       tgt_ff, tgt_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pidx_ff, pidx_in;
   logic [2:0]             op_ff, op_in;
   logic [HANDLE_BITS-1:0] hdl_ff, hdl_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       occ_ff, occ_in;
   logic [CNT_W-1:0]       alloc_ff, alloc_in;
   logic [SLOTS-1:0]       slot_busy_ff, slot_busy_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [HANDLE_BITS-1:0] slot_handle_mem [SLOTS];
   logic [HANDLE_BITS-1:0] rd_data_ff;
   logic                   wr_en, rd_en;
   logic [IDX_W-1:0]       wr_addr, rd_addr;
   logic [HANDLE_BITS-1:0] wr_data;
   logic [IDX_W-1:0]       scan_idx;

   assign scan_idx   = scan_ff[IDX_W-1:0];
   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Handle memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_handle_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_handle_mem[rd_addr];
      end
   end

   // Control and count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         pend_ff      <= 1'b0;
         occ_ff       <= '0;
         alloc_ff     <= CNT_W'(1);
         slot_busy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         occ_ff       <= occ_in;
         alloc_ff     <= alloc_in;
         slot_busy_ff <= slot_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and the response word.
   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      tgt_ff   <= tgt_in;
      pidx_ff  <= pidx_in;
      op_ff    <= op_in;
      hdl_ff   <= hdl_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   // Sequencer: request decode, slot scan, memory fetch and the remove-all sweep.
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      tgt_in       = tgt_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      op_in        = op_ff;
      hdl_in       = hdl_ff;
      count_in     = count_ff;
      occ_in       = occ_ff;
      alloc_in     = alloc_ff;
      slot_busy_in = slot_busy_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = hdl_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               op_in  = req_data.opcode;
               hdl_in = req_data.handle;
               tgt_in = req_data.slot_index;
               rsp_in = '0;
               unique case (req_data.opcode)
                  OP_INSERT: begin
                     if (req_data.handle == '0) begin
                        rsp_in.status = STS_ZERO;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        scan_in  = '0;
                        state_in = FSM_FIND;
                     end
                  end
                  OP_INSERT_AT: begin
                     rsp_valid_in = 1'b1;
                     if (req_data.handle == '0) begin
                        rsp_in.status = STS_ZERO;
                     end else if (CNT_W'(req_data.slot_index) >= alloc_ff) begin
                        rsp_in.status = STS_UNALLOC;
                     end else if (slot_busy_ff[req_data.slot_index]) begin
                        rsp_in.status = STS_MISS;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = req_data.slot_index;
                        wr_data = req_data.handle;
                        slot_busy_in[req_data.slot_index] = 1'b1;
                        occ_in  = occ_ff + CNT_W'(1);
                        rsp_in.status      = STS_DONE;
                        rsp_in.result_slot = req_data.slot_index;
                     end
                  end
                  OP_REMOVE_FIRST: begin
                     if (occ_ff == '0) begin
                        rsp_in.status = STS_MISS;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        scan_in  = '0;
                        state_in = FSM_FIND;
                     end
                  end
                  OP_REMOVE_AT: begin
                     if (CNT_W'(req_data.slot_index) >= alloc_ff) begin
                        rsp_in.status = STS_UNALLOC;
                        rsp_valid_in  = 1'b1;
                     end else if (!slot_busy_ff[req_data.slot_index]) begin
                        rsp_in.status = STS_MISS;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = req_data.slot_index;
                        state_in = FSM_FETCH;
                     end
                  end
                  OP_REMOVE_ALL: begin
                     if (req_data.handle == '0) begin
                        rsp_in.status = STS_ZERO;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        scan_in  = '0;
                        pend_in  = 1'b0;
                        count_in = '0;
                        state_in = FSM_SWEEP;
                     end
                  end
                  default: begin
                     rsp_in.status = STS_MISS;
                     rsp_valid_in  = 1'b1;
                  end
               endcase
            end
         end

         // One occupancy bit per cycle: first free slot for insert,
         // first held slot for remove first.
         FSM_FIND: begin
            if (op_ff == OP_INSERT) begin
               if (scan_ff == alloc_ff) begin
                  rsp_valid_in = 1'b1;
                  state_in     = FSM_IDLE;
                  if (alloc_ff < CNT_W'(SLOTS)) begin
                     wr_en    = 1'b1;
                     wr_addr  = alloc_ff[IDX_W-1:0];
                     slot_busy_in[alloc_ff[IDX_W-1:0]] = 1'b1;
                     occ_in   = occ_ff + CNT_W'(1);
                     alloc_in = alloc_ff + CNT_W'(1);
                     rsp_in.status      = STS_DONE;
                     rsp_in.result_slot = alloc_ff[IDX_W-1:0];
                  end else begin
                     rsp_in.status = STS_FULL;
                  end
               end else if (!slot_busy_ff[scan_idx]) begin
                  wr_en   = 1'b1;
                  wr_addr = scan_idx;
                  slot_busy_in[scan_idx] = 1'b1;
                  occ_in  = occ_ff + CNT_W'(1);
                  rsp_in.status      = STS_DONE;
                  rsp_in.result_slot = scan_idx;
                  rsp_valid_in = 1'b1;
                  state_in     = FSM_IDLE;
               end else begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end else begin
               if (scan_ff == alloc_ff) begin
                  rsp_in.status = STS_MISS;
                  rsp_valid_in  = 1'b1;
                  state_in      = FSM_IDLE;
               end else if (slot_busy_ff[scan_idx]) begin
                  rd_en    = 1'b1;
                  rd_addr  = scan_idx;
                  tgt_in   = scan_idx;
                  state_in = FSM_FETCH;
               end else begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end
         end

         // The read data is back: free the slot and return its handle.
         FSM_FETCH: begin
            slot_busy_in[tgt_ff]  = 1'b0;
            occ_in                = occ_ff - CNT_W'(1);
            rsp_in.status         = STS_DONE;
            rsp_in.removed_handle = rd_data_ff;
            rsp_valid_in          = 1'b1;
            state_in              = FSM_IDLE;
         end

         // Read one slot per cycle and compare the word read the cycle before.
         FSM_SWEEP: begin
            if (pend_ff && slot_busy_ff[pidx_ff] && (rd_data_ff == hdl_ff)) begin
               slot_busy_in[pidx_ff] = 1'b0;
               occ_in   = occ_ff - CNT_W'(1);
               count_in = count_ff + CNT_W'(1);
            end
            if (scan_ff < alloc_ff) begin
               rd_en   = 1'b1;
               rd_addr = scan_idx;
               pidx_in = scan_idx;
               pend_in = 1'b1;
               scan_in = scan_ff + CNT_W'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               rsp_in.status        = (count_ff != '0) ? STS_DONE : STS_MISS;
               rsp_in.removed_count = count_ff;
               rsp_valid_in         = 1'b1;
               state_in             = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      // Counts reported are those after this step.
      rsp_in.held_count      = occ_in;
      rsp_in.allocated_count = alloc_in;
   end

   // An accepted word leads to the sequencer working or a response next cycle.
   `SPB_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe)
   // A response never reports more held slots than allocated ones.
   `SPB_ASSERT_IMPLY(a_held_le_alloc, clock, reset, rsp_strobe, rsp_data.held_count <= rsp_data.allocated_count)
   // The allocated count stays within one and the pool size.
   `SPB_ASSERT_IMPLY(a_alloc_range, clock, reset, 1'b1, (alloc_ff != '0) && (alloc_ff <= CNT_W'(SLOTS)))
   // The held count always matches no more than the allocated slots.
   `SPB_ASSERT_IMPLY(a_occ_bound, clock, reset, 1'b1, occ_ff <= alloc_ff)

endmodule

// ===== tb/tb_slot_pool_bag_unit.sv =====
// Self-checking testbench for slot_pool_bag_unit: a directed table, then random traffic.
// Depends on spb_pkg for the request and response words and on the unit itself.
// Every response is checked against the directed table or a behavioral slot bag model.
module tb_slot_pool_bag_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import spb_pkg::*;

   localparam int ITEMS_PER_PHASE = 400;
   localparam int DRAIN_CYCLES    = 80;
   localparam int MAX_PRINTED     = 40;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   slot_pool_bag_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Model of the bag: handle and occupancy per slot, and the two counters.
   logic [HANDLE_BITS-1:0] bag_handle [SLOTS];
   bit                     bag_busy   [SLOTS];
   int                     bag_held;
   int                     bag_alloc;

   // Response words still owed by the unit, oldest first.
   rsp_type owed_q[$];

   // Directed table: a request and, where it is obvious, its response word.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } plan_row_type;
   plan_row_type plan_q[$];

   // Expectation attached to the word currently on the request port.
   bit      drive_typed;
   rsp_type drive_want;

   logic [HANDLE_BITS-1:0] handle_pool [16];
   int mismatches;
   int words_sent;
   int words_checked;
   int status_seen [8];

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_PRINTED)
         $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void bag_clear();
      for (int i = 0; i < SLOTS; i++) begin
         bag_handle[i] = '0;
         bag_busy[i]   = 1'b0;
      end
      bag_held  = 0;
      bag_alloc = 1;
   endfunction

   // Applies one request to the model and returns the response word it causes.
   function automatic rsp_type bag_apply(input req_type r);
      rsp_type w;
      int      hit;
      int      cleared;
      w        = '0;
      w.status = STS_MISS;
      hit      = -1;
      cleared  = 0;
      unique case (r.opcode)
         OP_INSERT: begin
            if (r.handle == '0) begin
               w.status = STS_ZERO;
            end else begin
               // First empty allocated slot, else grow the chain by one.
               for (int i = 0; i < bag_alloc; i++)
                  if (hit < 0 && !bag_busy[i]) hit = i;
               if (hit < 0 && bag_alloc < SLOTS) begin
                  hit = bag_alloc;
                  bag_alloc++;
               end
               if (hit < 0) begin
                  w.status = STS_FULL;
               end else begin
                  bag_handle[hit] = r.handle;
                  bag_busy[hit]   = 1'b1;
                  bag_held++;
                  w.status      = STS_DONE;
                  w.result_slot = IDX_W'(hit);
               end
            end
         end
         OP_INSERT_AT: begin
            if (r.handle == '0) begin
               w.status = STS_ZERO;
            end else if (int'(r.slot_index) >= bag_alloc) begin
               w.status = STS_UNALLOC;
            end else if (!bag_busy[r.slot_index]) begin
               bag_handle[r.slot_index] = r.handle;
               bag_busy[r.slot_index]   = 1'b1;
               bag_held++;
               w.status      = STS_DONE;
               w.result_slot = r.slot_index;
            end
         end
         OP_REMOVE_FIRST: begin
            for (int i = 0; i < bag_alloc; i++)
               if (hit < 0 && bag_busy[i]) hit = i;
            if (hit >= 0) begin
               w.removed_handle = bag_handle[hit];
               bag_busy[hit]    = 1'b0;
               bag_held--;
               w.status = STS_DONE;
            end
         end
         OP_REMOVE_AT: begin
            if (int'(r.slot_index) >= bag_alloc) begin
               w.status = STS_UNALLOC;
            end else if (bag_busy[r.slot_index]) begin
               w.removed_handle         = bag_handle[r.slot_index];
               bag_busy[r.slot_index]   = 1'b0;
               bag_held--;
               w.status = STS_DONE;
            end
         end
         OP_REMOVE_ALL: begin
            if (r.handle == '0) begin
               w.status = STS_ZERO;
            end else begin
               for (int i = 0; i < bag_alloc; i++) begin
                  if (bag_busy[i] && bag_handle[i] == r.handle) begin
                     bag_busy[i] = 1'b0;
                     bag_held--;
                     cleared++;
                  end
               end
               w.removed_count = CNT_W'(cleared);
               w.status        = (cleared != 0) ? STS_DONE : STS_MISS;
            end
         end
         default: w.status = STS_MISS;
      endcase
      w.held_count      = CNT_W'(bag_held);
      w.allocated_count = CNT_W'(bag_alloc);
      return w;
   endfunction

   task automatic plan(input logic [2:0] op, input int idx, input logic [31:0] h,
                       input bit typed, input status_type sts, input int rslot,
                       input logic [31:0] rhandle, input int rcount, input int held,
                       input int alloc);
      plan_row_type row;
      row.req.opcode             = op;
      row.req.slot_index         = IDX_W'(idx);
      row.req.handle             = h;
      row.typed                  = typed;
      row.want                   = '0;
      row.want.status            = sts;
      row.want.result_slot       = IDX_W'(rslot);
      row.want.removed_handle    = rhandle;
      row.want.removed_count     = CNT_W'(rcount);
      row.want.held_count        = CNT_W'(held);
      row.want.allocated_count   = CNT_W'(alloc);
      plan_q.push_back(row);
   endtask

   // Entered at a falling edge; returns at the falling edge once the word is accepted
   // and busy is low, with start still high, so the next word can follow without a gap.
   task automatic send_word(input req_type r, input bit typed, input rsp_type want,
                            input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      drive_typed = typed;
      drive_want  = want;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Opcode mix per phase: the first fills the chain, the second drains it, the third mixes.
   function automatic logic [2:0] pick_opcode(input int phase);
      int roll;
      int cut [3][5];
      cut  = '{'{55, 70, 78, 88, 94}, '{20, 30, 55, 75, 95}, '{33, 48, 63, 78, 95}};
      roll = $urandom_range(99);
      if (roll < cut[phase][0]) return OP_INSERT;
      if (roll < cut[phase][1]) return OP_INSERT_AT;
      if (roll < cut[phase][2]) return OP_REMOVE_FIRST;
      if (roll < cut[phase][3]) return OP_REMOVE_AT;
      if (roll < cut[phase][4]) return OP_REMOVE_ALL;
      return 3'($urandom_range(7, 5));
   endfunction

   // Handles mostly come from a small pool so that remove-all finds matches.
   function automatic req_type pick_request(input int phase);
      req_type r;
      int      roll;
      r.opcode = pick_opcode(phase);
      roll     = $urandom_range(99);
      if (roll < 70)      r.handle = handle_pool[$urandom_range(15)];
      else if (roll < 80) r.handle = '0;
      else                r.handle = $urandom;
      if ($urandom_range(99) < 75) r.slot_index = IDX_W'($urandom_range(bag_alloc - 1));
      else                         r.slot_index = IDX_W'($urandom_range(SLOTS - 1));
      return r;
   endfunction

   // Check each response word, then record the request accepted at this edge.
   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type owed;
      if (!reset) begin
         if (rsp_strobe) begin
            got = rsp_data;
            if (owed_q.size() == 0) begin
               report_mismatch("response word with no request outstanding");
            end else begin
               owed = owed_q.pop_front();
               if (got.status !== owed.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            got.status, owed.status));
               if (got.result_slot !== owed.result_slot)
                  report_mismatch($sformatf("result_slot got %0d want %0d",
                                            got.result_slot, owed.result_slot));
               if (got.removed_handle !== owed.removed_handle)
                  report_mismatch($sformatf("removed_handle got %h want %h",
                                            got.removed_handle, owed.removed_handle));
               if (got.removed_count !== owed.removed_count)
                  report_mismatch($sformatf("removed_count got %0d want %0d",
                                            got.removed_count, owed.removed_count));
               if (got.held_count !== owed.held_count)
                  report_mismatch($sformatf("held_count got %0d want %0d",
                                            got.held_count, owed.held_count));
               if (got.allocated_count !== owed.allocated_count)
                  report_mismatch($sformatf("allocated_count got %0d want %0d",
                                            got.allocated_count, owed.allocated_count));
               status_seen[owed.status]++;
               words_checked++;
            end
         end
         if (start && !busy) begin
            owed = bag_apply(req_data);
            owed_q.push_back(drive_typed ? drive_want : owed);
            words_sent++;
         end
      end
   end

   // Hard stop in case the unit hangs.
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      rsp_type none;
      int      idle_pct [3];
      idle_pct      = '{16, 88, 0};
      none          = '0;
      clock         = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      drive_typed   = 1'b0;
      drive_want    = '0;
      mismatches    = 0;
      words_sent    = 0;
      words_checked = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      bag_clear();

      // Pool of handles: the extremes plus random nonzero values.
      handle_pool[0] = 32'hFFFF_FFFF;
      handle_pool[1] = 32'h0000_0001;
      handle_pool[2] = 32'h8000_0000;
      for (int i = 3; i < 16; i++) handle_pool[i] = $urandom | 32'h1;

      // Empty bag, rejected requests, fills, targeted removes, unused codes.
      plan(OP_REMOVE_FIRST, 0,  32'h0,         1, STS_MISS,    0, 32'h0,         0, 0, 1);
      plan(OP_REMOVE_AT,    0,  32'h0,         1, STS_MISS,    0, 32'h0,         0, 0, 1);
      plan(OP_REMOVE_AT,    63, 32'h0,         1, STS_UNALLOC, 0, 32'h0,         0, 0, 1);
      plan(OP_INSERT,       0,  32'h0,         1, STS_ZERO,    0, 32'h0,         0, 0, 1);
      plan(OP_INSERT_AT,    63, 32'h0,         1, STS_ZERO,    0, 32'h0,         0, 0, 1);
      plan(OP_INSERT_AT,    1,  32'h1,         1, STS_UNALLOC, 0, 32'h0,         0, 0, 1);
      plan(OP_REMOVE_ALL,   0,  32'h0,         1, STS_ZERO,    0, 32'h0,         0, 0, 1);
      plan(OP_REMOVE_ALL,   0,  32'h5,         1, STS_MISS,    0, 32'h0,         0, 0, 1);
      plan(OP_INSERT,       63, 32'hFFFF_FFFF, 1, STS_DONE,    0, 32'h0,         0, 1, 1);
      plan(OP_INSERT_AT,    0,  32'h1,         1, STS_MISS,    0, 32'h0,         0, 1, 1);
      plan(OP_INSERT,       0,  32'h1,         1, STS_DONE,    1, 32'h0,         0, 2, 2);
      plan(OP_INSERT,       0,  32'hFFFF_FFFF, 1, STS_DONE,    2, 32'h0,         0, 3, 3);
      plan(OP_REMOVE_AT,    1,  32'h0,         1, STS_DONE,    0, 32'h1,         0, 2, 3);
      plan(OP_INSERT_AT,    1,  32'h8000_0000, 1, STS_DONE,    1, 32'h0,         0, 3, 3);
      plan(OP_REMOVE_ALL,   0,  32'hFFFF_FFFF, 1, STS_DONE,    0, 32'h0,         2, 1, 3);
      plan(OP_REMOVE_FIRST, 0,  32'h0,         1, STS_DONE,    0, 32'h8000_0000, 0, 0, 3);
      plan(3'd5,            0,  32'h0,         1, STS_MISS,    0, 32'h0,         0, 0, 3);
      plan(3'd6,            63, 32'hFFFF_FFFF, 0, STS_MISS,    0, 32'h0,         0, 0, 0);
      plan(3'd7,            21, 32'h1234_5678, 0, STS_MISS,    0, 32'h0,         0, 0, 0);
      plan(OP_INSERT,       0,  32'h2,         0, STS_DONE,    0, 32'h0,         0, 0, 0);
      plan(OP_REMOVE_AT,    2,  32'h0,         0, STS_DONE,    0, 32'h0,         0, 0, 0);
      plan(OP_INSERT_AT,    2,  32'h1,         0, STS_DONE,    0, 32'h0,         0, 0, 0);
      plan(OP_INSERT,       0,  32'h1,         0, STS_DONE,    0, 32'h0,         0, 0, 0);
      plan(OP_REMOVE_ALL,   0,  32'h1,         0, STS_DONE,    0, 32'h0,         0, 0, 0);
      plan(OP_REMOVE_AT,    3,  32'h0,         0, STS_DONE,    0, 32'h0,         0, 0, 0);

      // Synchronous reset, released on a falling edge.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan_q[i])
         send_word(plan_q[i].req, plan_q[i].typed, plan_q[i].want, idle_pct[0]);

      // Random traffic: fill the chain, drain it, then a balanced mix.
      for (int phase = 0; phase < 3; phase++)
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_word(pick_request(phase), 1'b0, none, idle_pct[phase]);
      start <= 1'b0;

      // Wait for every owed word, then watch for stray strobes a while longer.
      while (owed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d response words for %0d request words, %0d slots allocated.",
               words_checked, words_sent, bag_alloc);
      $display("Status seen: done %0d, miss %0d, full %0d, unallocated %0d, zero %0d.",
               status_seen[STS_DONE], status_seen[STS_MISS], status_seen[STS_FULL],
               status_seen[STS_UNALLOC], status_seen[STS_ZERO]);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
